FILE: hw/rtl/command_stream_deframer_defines.svh
// Assertion macros for the command stream deframer.
// Both sample on the rising edge of clk and are disabled while rst_n is low.
`ifndef COMMAND_STREAM_DEFRAMER_DEFINES_SVH
`define COMMAND_STREAM_DEFRAMER_DEFINES_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define CSD_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CSD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CSD_ASSERT(lbl, ante, cons, msg)

`define CSD_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: hw/rtl/csd_pkg.sv
`default_nettype none

package csd_pkg;

    localparam logic [7:0] NAK_BYTE = 8'h15;
    localparam logic [7:0] STX_BYTE = 8'h02;
    localparam logic [7:0] KIND_VAR = 8'h62;
    localparam logic [7:0] TYPE_LO  = 8'h50;
    localparam logic [7:0] TYPE_HI  = 8'h76;

    localparam logic [4:0] VAR_POS   = 5'd5;
    localparam int         VAR_BIT   = 4;
    localparam logic [4:0] LEN_SHORT = 5'd9;
    localparam logic [4:0] LEN_LONG  = 5'd23;
    localparam logic [4:0] POS_MAX   = 5'd31;

    localparam int MAX_RES     = 3;
    localparam int QUEUE_DEPTH = 4;

    localparam int TABLE_LEN = 39;

    // frame length per type 0x50..0x76, zero for an unknown type
    localparam logic [4:0] LEN_TABLE [TABLE_LEN] = '{
        5'd11, 5'd25, 5'd4,  5'd10, 5'd3,  5'd2,  5'd13, 5'd10, 5'd3,  5'd12,
        5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,
        5'd9,  5'd6,  5'd23, 5'd5,  5'd5,  5'd3,  5'd6,  5'd3,  5'd4,  5'd3,
        5'd3,  5'd4,  5'd3,  5'd3,  5'd3,  5'd12,
        5'd4,  5'd5,  5'd3,  5'd6,  5'd0,  5'd5,  5'd13
    };

    typedef enum logic [1:0] {
        PH_IDLE      = 2'd0,
        PH_AFTER_NAK = 2'd1,
        PH_HELD      = 2'd2,
        PH_FRAME     = 2'd3
    } phase_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_first;
        logic       frame_last;
        logic [7:0] frame_kind;
        logic       nak_seen;
        logic       start_inserted;
        logic       discard_error;
    } res_t;

    // all results caused by one input byte
    typedef struct packed {
        logic [1:0]              cnt;
        res_t [MAX_RES-1:0]      slot;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        logic [4:0] left;
        logic [4:0] pos;
        logic       first;
        logic       last;
    } fb_t;

    function automatic logic [4:0] type_len(input logic [7:0] t);
        logic [7:0] off;
        off = t - TYPE_LO;
        if (t < TYPE_LO || t > TYPE_HI)
            return 5'd0;
        return LEN_TABLE[off[5:0]];
    endfunction

    // one byte of the current frame; left counts the byte being emitted
    function automatic fb_t frame_step(input logic [7:0] kind, input logic [4:0] left,
                                       input logic [4:0] pos, input logic [7:0] b);
        fb_t        r;
        logic [4:0] l;
        l = left;
        if (kind == KIND_VAR && pos == VAR_POS)
            l = b[VAR_BIT] ? (LEN_LONG - VAR_POS) : (LEN_SHORT - VAR_POS);
        r.left  = (l != 5'd0) ? l - 5'd1 : 5'd0;
        r.last  = (r.left == 5'd0);
        r.first = (pos == 5'd0);
        r.pos   = (pos != POS_MAX) ? pos + 5'd1 : pos;
        return r;
    endfunction

    function automatic res_t frame_res(input logic [7:0] b, input logic [7:0] kind,
                                       input fb_t f, input logic ins);
        res_t r;
        r                = '0;
        r.out_byte       = b;
        r.frame_first    = f.first;
        r.frame_last     = f.last;
        r.frame_kind     = kind;
        r.start_inserted = ins;
        return r;
    endfunction

    function automatic res_t nak_res();
        res_t r;
        r             = '0;
        r.out_byte    = NAK_BYTE;
        r.frame_first = 1'b1;
        r.frame_last  = 1'b1;
        r.frame_kind  = NAK_BYTE;
        r.nak_seen    = 1'b1;
        return r;
    endfunction

    function automatic res_t err_res(input logic [7:0] kind);
        res_t r;
        r               = '0;
        r.frame_kind    = kind;
        r.discard_error = 1'b1;
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/csd_in_if.sv
`default_nettype none

interface csd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/csd_out_if.sv
`default_nettype none

interface csd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       frame_first;
    logic       frame_last;
    logic [7:0] frame_kind;
    logic       nak_seen;
    logic       start_inserted;
    logic       discard_error;
    logic       run_last;

    modport source (
        output valid, output out_byte, output frame_first, output frame_last,
        output frame_kind, output nak_seen, output start_inserted,
        output discard_error, output run_last, input ready
    );
    modport sink (
        input valid, input out_byte, input frame_first, input frame_last,
        input frame_kind, input nak_seen, input start_inserted,
        input discard_error, input run_last, output ready
    );
endinterface

`default_nettype wire

FILE: hw/rtl/csd_cfg_if.sv
`default_nettype none

interface csd_cfg_if;
    logic valid;
    logic ready;
    logic repair_missing_start;

    modport source (output valid, output repair_missing_start, input ready);
    modport sink (input valid, input repair_missing_start, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/csd_front.sv
`default_nettype none

module csd_front (
    input  wire               clk,
    input  wire               rst_n,
    csd_in_if.sink            rx,
    csd_cfg_if.sink           cfg,
    input  csd_pkg::q_stat_t  q_stat,
    output logic              push,
    output csd_pkg::entry_t   push_ent
);

    logic             repair_reg;
    csd_pkg::phase_t  phase_reg;
    csd_pkg::phase_t  phase_next;
    csd_pkg::phase_t  phase_step;
    logic [7:0]       held_reg;
    logic [7:0]       held_next;
    logic [7:0]       kind_reg;
    logic [7:0]       kind_next;
    logic [4:0]       left_reg;
    logic [4:0]       left_next;
    logic [4:0]       pos_reg;
    logic [4:0]       pos_next;

    logic             acc;
    logic [7:0]       b;
    logic [4:0]       len_b;
    logic [4:0]       len_h;
    csd_pkg::fb_t     f0;
    csd_pkg::fb_t     f1;
    csd_pkg::fb_t     f2;
    csd_pkg::entry_t  ent;

    assign rx.ready  = !q_stat.full;
    assign cfg.ready = 1'b1;
    assign acc       = rx.valid && rx.ready;
    assign b         = rx.rx_byte;
    assign len_b     = csd_pkg::type_len(b);
    assign len_h     = csd_pkg::type_len(held_reg);

    // classify the byte and build every result it causes
    always_comb
    begin
        phase_step = phase_reg;
        held_next  = held_reg;
        kind_next  = kind_reg;
        left_next  = left_reg;
        pos_next   = pos_reg;
        f0         = '0;
        f1         = '0;
        f2         = '0;
        ent        = '0;
        unique case (phase_reg)
            csd_pkg::PH_IDLE, csd_pkg::PH_AFTER_NAK:
            begin
                if (b == csd_pkg::NAK_BYTE)
                begin
                    if (phase_reg == csd_pkg::PH_AFTER_NAK)
                    begin
                        phase_step = csd_pkg::PH_IDLE;
                    end
                    else
                    begin
                        ent.slot[0] = csd_pkg::nak_res();
                        ent.cnt     = 2'd1;
                        phase_step  = csd_pkg::PH_AFTER_NAK;
                    end
                end
                else
                begin
                    held_next  = b;
                    phase_step = csd_pkg::PH_HELD;
                end
            end
            csd_pkg::PH_HELD:
            begin
                if (len_b != 5'd0)
                begin
                    kind_next   = b;
                    f0          = csd_pkg::frame_step(b, len_b, 5'd0, held_reg);
                    ent.slot[0] = csd_pkg::frame_res(held_reg, b, f0, 1'b0);
                    ent.cnt     = 2'd1;
                    if (!f0.last)
                    begin
                        f1          = csd_pkg::frame_step(b, f0.left, f0.pos, b);
                        ent.slot[1] = csd_pkg::frame_res(b, b, f1, 1'b0);
                        ent.cnt     = 2'd2;
                        left_next   = f1.left;
                        pos_next    = f1.pos;
                        phase_step  = f1.last ? csd_pkg::PH_IDLE : csd_pkg::PH_FRAME;
                    end
                    else
                    begin
                        // a known type is never a NAK, so it is simply held
                        left_next  = f0.left;
                        pos_next   = f0.pos;
                        held_next  = b;
                        phase_step = csd_pkg::PH_HELD;
                    end
                end
                else if (repair_reg && len_h != 5'd0)
                begin
                    kind_next   = held_reg;
                    f0          = csd_pkg::frame_step(held_reg, len_h, 5'd0,
                                                      csd_pkg::STX_BYTE);
                    ent.slot[0] = csd_pkg::frame_res(csd_pkg::STX_BYTE, held_reg, f0, 1'b1);
                    f1          = csd_pkg::frame_step(held_reg, f0.left, f0.pos, held_reg);
                    ent.slot[1] = csd_pkg::frame_res(held_reg, held_reg, f1, 1'b0);
                    ent.cnt     = 2'd2;
                    if (!f1.last)
                    begin
                        f2          = csd_pkg::frame_step(held_reg, f1.left, f1.pos, b);
                        ent.slot[2] = csd_pkg::frame_res(b, held_reg, f2, 1'b0);
                        ent.cnt     = 2'd3;
                        left_next   = f2.left;
                        pos_next    = f2.pos;
                        phase_step  = f2.last ? csd_pkg::PH_IDLE : csd_pkg::PH_FRAME;
                    end
                    else
                    begin
                        // repaired frame already complete: type byte starts over
                        left_next = f1.left;
                        pos_next  = f1.pos;
                        if (b == csd_pkg::NAK_BYTE)
                        begin
                            ent.slot[2] = csd_pkg::nak_res();
                            ent.cnt     = 2'd3;
                            phase_step  = csd_pkg::PH_AFTER_NAK;
                        end
                        else
                        begin
                            held_next  = b;
                            phase_step = csd_pkg::PH_HELD;
                        end
                    end
                end
                else
                begin
                    ent.slot[0] = csd_pkg::err_res(b);
                    ent.cnt     = 2'd1;
                    phase_step  = csd_pkg::PH_IDLE;
                end
            end
            csd_pkg::PH_FRAME:
            begin
                f0          = csd_pkg::frame_step(kind_reg, left_reg, pos_reg, b);
                ent.slot[0] = csd_pkg::frame_res(b, kind_reg, f0, 1'b0);
                ent.cnt     = 2'd1;
                left_next   = f0.left;
                pos_next    = f0.pos;
                phase_step  = f0.last ? csd_pkg::PH_IDLE : csd_pkg::PH_FRAME;
            end
        endcase
    end

    always_comb
    begin
        phase_next = acc ? phase_step : phase_reg;
    end

    always_comb
    begin
        push     = acc && (ent.cnt != 2'd0);
        push_ent = ent;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repair_reg <= 1'b1;
            phase_reg  <= csd_pkg::PH_IDLE;
            held_reg   <= 8'd0;
            kind_reg   <= 8'd0;
            left_reg   <= 5'd0;
            pos_reg    <= 5'd0;
        end
        else
        begin
            if (cfg.valid)
                repair_reg <= cfg.repair_missing_start;
            phase_reg <= phase_next;
            if (acc)
            begin
                held_reg <= held_next;
                kind_reg <= kind_next;
                left_reg <= left_next;
                pos_reg  <= pos_next;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/csd_fifo.sv
`default_nettype none

module csd_fifo #(
    parameter int DEPTH = csd_pkg::QUEUE_DEPTH
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               push,
    input  csd_pkg::entry_t   push_ent,
    input  wire               pop,
    output csd_pkg::entry_t   head,
    output csd_pkg::q_stat_t  stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    csd_pkg::entry_t  entry_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             do_push;
    logic             do_pop;

    assign stat.full  = (count_reg == CW'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_ent;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/csd_back.sv
`default_nettype none

module csd_back (
    input  wire               clk,
    input  wire               rst_n,
    input  csd_pkg::entry_t   head,
    input  csd_pkg::q_stat_t  q_stat,
    output logic              pop,
    csd_out_if.source         tx
);

    logic [1:0]     idx_reg;
    logic [1:0]     idx_next;
    logic           valid_reg;
    logic           valid_next;
    csd_pkg::res_t  res_reg;
    logic           run_last_reg;
    logic           load;
    logic           run_end;

    // output register frees whenever it is empty or being taken
    assign load    = !q_stat.empty && (!valid_reg || tx.ready);
    assign run_end = (idx_reg == head.cnt - 2'd1);
    assign pop     = load && run_end;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            idx_next   = run_end ? 2'd0 : idx_reg + 2'd1;
            valid_next = 1'b1;
        end
        else if (tx.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg      <= head.slot[idx_reg];
            run_last_reg <= run_end;
        end
    end

    assign tx.valid          = valid_reg;
    assign tx.out_byte       = res_reg.out_byte;
    assign tx.frame_first    = res_reg.frame_first;
    assign tx.frame_last     = res_reg.frame_last;
    assign tx.frame_kind     = res_reg.frame_kind;
    assign tx.nak_seen       = res_reg.nak_seen;
    assign tx.start_inserted = res_reg.start_inserted;
    assign tx.discard_error  = res_reg.discard_error;
    assign tx.run_last       = run_last_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/command_stream_deframer.sv
// Channel | Dir | Payload                                  | Transfer
// --------+-----+------------------------------------------+-------------------
// rx      | in  | rx_byte[7:0]                             | valid && ready
// tx      | out | out_byte, frame_first, frame_last,       | valid && ready
//         |     | frame_kind, nak_seen, start_inserted,    |
//         |     | discard_error, run_last                  |
// cfg     | in  | repair_missing_start                     | valid && ready
//
// While the queue has room, the front end decodes one byte per cycle into up to
// three results and queues them. The back end sends one result per cycle while
// tx.ready is high; sustained rate is set by the single-result output register.
// rx.ready drops only while the result queue is full; cfg.ready is always high.
// Reset (rst_n low, async) leaves the deframer at a frame boundary with repair on.
// A byte's results pass through the result queue and then the output register, which
// drives tx.valid.

`default_nettype none

`include "command_stream_deframer_defines.svh"

module command_stream_deframer #(
    parameter int QUEUE_DEPTH = csd_pkg::QUEUE_DEPTH
) (
    input wire       clk,
    input wire       rst_n,
    csd_in_if.sink   rx,
    csd_out_if.source tx,
    csd_cfg_if.sink  cfg
);

    logic              push;
    logic              pop;
    csd_pkg::entry_t   push_ent;
    csd_pkg::entry_t   head;
    csd_pkg::q_stat_t  q_stat;

    csd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx       (rx),
        .cfg      (cfg),
        .q_stat   (q_stat),
        .push     (push),
        .push_ent (push_ent)
    );

    csd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_ent (push_ent),
        .pop      (pop),
        .head     (head),
        .stat     (q_stat)
    );

    csd_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .q_stat (q_stat),
        .pop    (pop),
        .tx     (tx)
    );

    `CSD_ASSERT(a_nak_shape, tx.valid && tx.nak_seen, tx.frame_first && tx.frame_last && tx.out_byte == csd_pkg::NAK_BYTE, "NAK result malformed")
    `CSD_ASSERT(a_err_alone, tx.valid && tx.discard_error, tx.run_last && !tx.frame_first, "error result not alone")
    `CSD_ASSERT(a_ins_first, tx.valid && tx.start_inserted, tx.frame_first && !tx.run_last, "inserted start misplaced")
    `CSD_ASSERT(a_q_stat, 1'b1, !(q_stat.full && q_stat.empty), "queue both full and empty")
    `CSD_ASSERT_NEXT(a_push_lands, push && q_stat.empty, !q_stat.empty, "pushed entry lost")

endmodule

`default_nettype wire

FILE: verif/command_stream_deframer_test.sv
`default_nettype none

module command_stream_deframer_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_first;
        logic       frame_last;
        logic [7:0] frame_kind;
        logic       nak_seen;
        logic       start_inserted;
        logic       discard_error;
        logic       run_last;
    } deframed_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       cfg_wr;
        logic       cfg_val;
        logic       typed;
        deframed_t  res;
    } step_row_t;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DIRECTED_ROWS = 24;
    localparam int RUN_ITEMS = 80;
    localparam bit REPAIR_RUNS [4] = '{1'b0, 1'b1, 1'b0, 1'b1};

    // frame length per type TYPE_LO..TYPE_HI, zero marks an unknown type
    localparam logic [4:0] FRAME_LEN [39] = '{
        5'd11, 5'd25, 5'd4,  5'd10, 5'd3,  5'd2,  5'd13, 5'd10, 5'd3,  5'd12,
        5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,
        5'd9,  5'd6,  5'd23, 5'd5,  5'd5,  5'd3,  5'd6,  5'd3,  5'd4,  5'd3,
        5'd3,  5'd4,  5'd3,  5'd3,  5'd3,  5'd12,
        5'd4,  5'd5,  5'd3,  5'd6,  5'd0,  5'd5,  5'd13
    };

    localparam deframed_t NAK_RESULT =
        '{csd_pkg::NAK_BYTE, 1'b1, 1'b1, csd_pkg::NAK_BYTE, 1'b1, 1'b0, 1'b0, 1'b1};

    localparam step_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{8'h15, 1'b0, 1'b0, 1'b1, NAK_RESULT},
        '{8'h15, 1'b0, 1'b0, 1'b0, '0},            // second NAK dropped
        '{8'h15, 1'b0, 1'b0, 1'b1, NAK_RESULT},
        '{8'h00, 1'b0, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, 8'hFF, 1'b0, 1'b0, 1'b1, 1'b1}},
        '{8'h02, 1'b0, 1'b0, 1'b0, '0},
        '{8'h55, 1'b0, 1'b0, 1'b0, '0},            // shortest frame
        '{8'h02, 1'b0, 1'b0, 1'b0, '0},
        '{8'h62, 1'b0, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, '0},
        '{8'h80, 1'b0, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, 1'b0, '0},            // offset 5, bit 4 clear: short
        '{8'hA5, 1'b0, 1'b0, 1'b0, '0},
        '{8'h5A, 1'b0, 1'b0, 1'b0, '0},
        '{8'h3C, 1'b0, 1'b0, 1'b0, '0},
        '{8'h55, 1'b0, 1'b0, 1'b0, '0},
        '{8'h15, 1'b0, 1'b0, 1'b0, '0},            // repair, then NAK on the type byte
        '{8'h54, 1'b0, 1'b0, 1'b0, '0},
        '{8'h40, 1'b0, 1'b0, 1'b0, '0},            // repair, three-byte frame
        '{8'h55, 1'b1, 1'b0, 1'b0, '0},
        '{8'h15, 1'b0, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, 8'h15, 1'b0, 1'b0, 1'b1, 1'b1}},
        '{8'hFF, 1'b0, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1}}
    };

    logic clk;
    logic rst_n;

    csd_in_if  rx ();
    csd_out_if tx ();
    csd_cfg_if cfg ();

    command_stream_deframer i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx),
        .tx    (tx),
        .cfg   (cfg)
    );

    // deframer model state
    logic             repair_on = 1'b1;
    csd_pkg::phase_t  ph = csd_pkg::PH_IDLE;
    logic [7:0]       held_q = '0;
    logic [7:0]       kind_q = '0;
    logic [4:0]       left_q = '0;
    logic [4:0]       pos_q = '0;

    deframed_t  step_q [$];
    deframed_t  frames_due [$];
    logic [7:0] stim_q [$];

    int fail_count = 0;
    int cycle_count = 0;
    int burst_left = 0;
    int stall_mode = 0;
    int stall_span = 0;
    int stall_tick = 0;

    function automatic logic [4:0] kind_length(input logic [7:0] t);
        if (t < csd_pkg::TYPE_LO || t > csd_pkg::TYPE_HI)
            return 5'd0;
        return FRAME_LEN[t - csd_pkg::TYPE_LO];
    endfunction

    function automatic void start_frame(input logic [7:0] k);
        kind_q = k;
        left_q = kind_length(k);
        pos_q  = 5'd0;
        ph     = csd_pkg::PH_FRAME;
    endfunction

    function automatic void emit_frame_byte(input logic [7:0] b, input logic ins);
        logic fst;
        logic lst;
        fst = (pos_q == 5'd0);
        if (kind_q == csd_pkg::KIND_VAR && pos_q == csd_pkg::VAR_POS)
            left_q = b[csd_pkg::VAR_BIT] ? csd_pkg::LEN_LONG - csd_pkg::VAR_POS
                                         : csd_pkg::LEN_SHORT - csd_pkg::VAR_POS;
        if (left_q != 5'd0)
            left_q = left_q - 5'd1;
        lst = (left_q == 5'd0);
        step_q.insert(step_q.size(), deframed_t'{b, fst, lst, kind_q, 1'b0, ins, 1'b0, 1'b0});
        if (pos_q != csd_pkg::POS_MAX)
            pos_q = pos_q + 5'd1;
        if (lst)
            ph = csd_pkg::PH_IDLE;
    endfunction

    function automatic void boundary_byte(input logic [7:0] b);
        if (b == csd_pkg::NAK_BYTE)
        begin
            if (ph == csd_pkg::PH_AFTER_NAK)
            begin
                ph = csd_pkg::PH_IDLE;
            end
            else
            begin
                step_q.insert(step_q.size(), NAK_RESULT);
                ph = csd_pkg::PH_AFTER_NAK;
            end
        end
        else
        begin
            held_q = b;
            ph     = csd_pkg::PH_HELD;
        end
    endfunction

    // fills step_q with the results one received byte causes
    function automatic void deframe_byte(input logic [7:0] b);
        logic [7:0] h;
        step_q.delete();
        case (ph)
            csd_pkg::PH_IDLE, csd_pkg::PH_AFTER_NAK: boundary_byte(b);
            csd_pkg::PH_HELD:
            begin
                h = held_q;
                if (kind_length(b) != 5'd0)
                begin
                    start_frame(b);
                    emit_frame_byte(h, 1'b0);
                    if (ph == csd_pkg::PH_FRAME)
                        emit_frame_byte(b, 1'b0);
                    else
                        boundary_byte(b);
                end
                else if (repair_on && kind_length(h) != 5'd0)
                begin
                    start_frame(h);
                    emit_frame_byte(csd_pkg::STX_BYTE, 1'b1);
                    emit_frame_byte(h, 1'b0);
                    if (ph == csd_pkg::PH_FRAME)
                        emit_frame_byte(b, 1'b0);
                    else
                        boundary_byte(b);
                end
                else
                begin
                    step_q.insert(step_q.size(),
                                  deframed_t'{8'h00, 1'b0, 1'b0, b, 1'b0, 1'b0, 1'b1, 1'b0});
                    ph = csd_pkg::PH_IDLE;
                end
            end
            default: emit_frame_byte(b, 1'b0);
        endcase
        if (step_q.size() != 0)
            step_q[step_q.size() - 1].run_last = 1'b1;
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic drive_byte(input logic [7:0] b, input logic typed, input deframed_t res);
        rx.valid   <= 1'b1;
        rx.rx_byte <= b;
        do
            @(posedge clk);
        while (!rx.ready);
        deframe_byte(b);
        if (typed)
            frames_due.insert(frames_due.size(), res);
        else
            foreach (step_q[i])
                frames_due.insert(frames_due.size(), step_q[i]);
        @(negedge clk);
    endtask

    // sender bursts with random gaps; some bursts are long stretches with no idling
    task automatic pace();
        int gap;
        burst_left--;
        if (burst_left <= 0)
        begin
            gap        = $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 4) == 0) ? 48 : $urandom_range(1, 12);
            rx.valid   <= 1'b0;
            rx.rx_byte <= 8'($urandom);
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic write_repair(input logic v);
        rx.valid <= 1'b0;
        while (frames_due.size() != 0)
            @(posedge clk);
        // a held byte may still be in flight with no result
        repeat (8) @(posedge clk);
        @(negedge clk);
        cfg.valid                <= 1'b1;
        cfg.repair_missing_start <= v;
        do
            @(posedge clk);
        while (!cfg.ready);
        repair_on = v;
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic build_random_run(input int n);
        logic [7:0] t;
        logic [7:0] b5;
        int         pick;
        int         flen;
        stim_q.delete();
        while (stim_q.size() < n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
            begin
                do
                    t = 8'($urandom_range(csd_pkg::TYPE_LO, csd_pkg::TYPE_HI));
                while (kind_length(t) == 5'd0);
                b5   = 8'($urandom);
                flen = (t == csd_pkg::KIND_VAR)
                     ? (b5[csd_pkg::VAR_BIT] ? csd_pkg::LEN_LONG : csd_pkg::LEN_SHORT)
                     : kind_length(t);
                // now and then the start byte is left out
                if ($urandom_range(0, 6) != 0)
                    stim_q.insert(stim_q.size(), csd_pkg::STX_BYTE);
                stim_q.insert(stim_q.size(), t);
                for (int i = 2; i < flen; i++)
                    stim_q.insert(stim_q.size(),
                                  (t == csd_pkg::KIND_VAR && i == csd_pkg::VAR_POS)
                                  ? b5 : 8'($urandom));
            end
            else if (pick < 75)
            begin
                stim_q.insert(stim_q.size(), csd_pkg::NAK_BYTE);
                if ($urandom_range(0, 1) != 0)
                    stim_q.insert(stim_q.size(), csd_pkg::NAK_BYTE);
            end
            else if (pick < 87)
            begin
                stim_q.insert(stim_q.size(),
                              ($urandom_range(0, 1) != 0) ? csd_pkg::STX_BYTE : 8'($urandom));
                do
                    t = 8'($urandom);
                while (kind_length(t) != 5'd0);
                stim_q.insert(stim_q.size(), t);
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                    stim_q.insert(stim_q.size(), 8'($urandom));
            end
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // receiver stall pattern, each random mode held for a random span
    initial
    begin
        tx.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_span == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_span = $urandom_range(20, 80);
            end
            stall_span--;
            stall_tick++;
            case (stall_mode)
                0:       tx.ready <= 1'b1;
                1:       tx.ready <= ($urandom_range(0, 3) != 0);
                2:       tx.ready <= (stall_tick % 5 == 0);
                default: tx.ready <= ($urandom_range(0, 1) != 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        deframed_t got;
        deframed_t want;
        if (rst_n && tx.valid && tx.ready)
        begin
            got = '{tx.out_byte, tx.frame_first, tx.frame_last, tx.frame_kind,
                    tx.nak_seen, tx.start_inserted, tx.discard_error, tx.run_last};
            if (frames_due.size() == 0)
            begin
                $display("%0t: transfer with nothing pending, expected none, actual %p",
                         $time, got);
                fail_count++;
            end
            else
            begin
                want = frames_due.pop_front();
                if (got !== want)
                begin
                    $display("%0t: result mismatch, expected %p, actual %p", $time, want, got);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        rx.valid                 = 1'b0;
        rx.rx_byte               = '0;
        cfg.valid                = 1'b0;
        cfg.repair_missing_start = 1'b1;
        rst_n                    = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // repair starts out at its reset value
        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            if (DIRECTED[r].cfg_wr)
                write_repair(DIRECTED[r].cfg_val);
            drive_byte(DIRECTED[r].rx_byte, DIRECTED[r].typed, DIRECTED[r].res);
            pace();
        end

        foreach (REPAIR_RUNS[p])
        begin
            write_repair(REPAIR_RUNS[p]);
            build_random_run(RUN_ITEMS);
            foreach (stim_q[i])
            begin
                drive_byte(stim_q[i], 1'b0, '0);
                pace();
            end
        end

        rx.valid <= 1'b0;
        while (frames_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
